// ----- design/jtl_pkg.sv -----
package jtl_pkg;

    // item classes, decided partly in the front and partly in the back
    typedef enum logic [1:0] {
        KIND_STEP,
        KIND_PRESET,
        KIND_SNAP,
        KIND_SKIP
    } jtl_kind_t;

    // register indexes on the config port
    localparam logic CFG_VELOCITY_LIMIT     = 1'b0;
    localparam logic CFG_ACCELERATION_LIMIT = 1'b1;

    localparam logic [29:0] VEL_LIMIT_RESET = 30'd33554432;
    localparam logic [30:0] ACC_LIMIT_RESET = 31'd50331648;
    // (acc + 500) / 1000 and vlim^2 for the reset limits
    localparam logic [21:0] STEP_RESET      = 22'd50332;
    localparam logic [59:0] VSQ_RESET       = 60'd1 << 50;

    localparam logic [31:0] HALF_TICKS      = 32'd500;
    // floor(x / 1000) == (x * DIV1000_MUL) >> DIV1000_SHIFT for any 32-bit x
    localparam logic [28:0] DIV1000_MUL     = 29'd274877907;
    localparam int          DIV1000_SHIFT   = 38;

    localparam int SQRT_STEPS  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
    localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;

    typedef struct packed {
        jtl_kind_t   kind;
        logic [2:0]  joint;
        logic [31:0] desired;
    } jtl_item_t;

    typedef struct packed {
        logic      valid;
        jtl_item_t item;
    } jtl_head_t;

    typedef struct packed {
        logic [29:0] vlim;
        logic [30:0] acc;
        logic [21:0] step;
        logic [59:0] vsq;
    } jtl_limits_t;

    typedef struct packed {
        jtl_kind_t   kind;
        logic [2:0]  joint;
        logic [31:0] desired;
        logic [31:0] pos;
        logic [31:0] vel;
        logic        errneg;
        logic        cmp;
    } jtl_ctx_t;

    function automatic logic [31:0] sat32(input logic signed [47:0] x);
        logic [31:0] r;
        if (x > SAT_MAX) begin
            r = 32'h7FFF_FFFF;
        end else if (x < SAT_MIN) begin
            r = 32'h8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ----- design/jtl_front.sv -----
module jtl_front import jtl_pkg::*; #(
    parameter int NUM_JOINTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    output jtl_head_t   head,
    input  logic        pop
);

    jtl_item_t             queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic                  push;
    jtl_item_t             item_in;

    assign s_tready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;

    // classify: joints past the configured count leave the state alone
    always_comb begin
        item_in.joint   = s_tdata[2:0];
        item_in.desired = s_tdata[34:3];
        if (32'(s_tdata[2:0]) >= NUM_JOINTS) begin
            item_in.kind = KIND_SKIP;
        end else if (s_tuser) begin
            item_in.kind = KIND_PRESET;
        end else begin
            item_in.kind = KIND_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = queue_reg[rd_ptr_reg];

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");
`endif

endmodule

// ----- design/jtl_isqrt.sv -----
module jtl_isqrt import jtl_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    logic [63:0] rem_reg [SQRT_STEPS];
    logic [63:0] res_reg [SQRT_STEPS];

    // one result bit per stage, digit-by-digit method
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                logic [63:0] n_in;
                logic [63:0] r_in;
                logic [63:0] bitv;
                logic [63:0] t;
                if (k == 0) begin
                    n_in = radicand;
                    r_in = '0;
                end else begin
                    n_in = rem_reg[k-1];
                    r_in = res_reg[k-1];
                end
                bitv = 64'd1 << (62 - 2*k);
                t    = r_in + bitv;
                if (n_in >= t) begin
                    rem_reg[k] <= n_in - t;
                    res_reg[k] <= (r_in >> 1) + bitv;
                end else begin
                    rem_reg[k] <= n_in;
                    res_reg[k] <= r_in >> 1;
                end
            end
        end
    end

    assign root = res_reg[SQRT_STEPS-1][31:0];

endmodule

// ----- design/jtl_back.sv -----
module jtl_back import jtl_pkg::*; #(
    parameter int NUM_JOINTS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  jtl_head_t    head,
    output logic         pop,
    input  jtl_limits_t  limits,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata
);

    localparam int NJ = (NUM_JOINTS < 8) ? NUM_JOINTS : 8;
    localparam int JW = (NJ > 1) ? $clog2(NJ) : 1;

    logic [31:0] pos_reg  [NJ];
    logic [31:0] vel_reg  [NJ];
    logic        busy_reg [NJ];

    logic        adv;
    logic [JW-1:0] head_idx;

    // stage valids and payloads
    logic        a_valid_reg, b_valid_reg, c_valid_reg;
    logic        e_valid_reg, g_valid_reg, r_valid_reg, o_valid_reg;
    logic        line_valid_reg [SQRT_STEPS];
    jtl_ctx_t    a_ctx_reg, b_ctx_reg, c_ctx_reg, e_ctx_reg, g_ctx_reg, r_ctx_reg;
    jtl_ctx_t    line_reg [SQRT_STEPS];
    logic [31:0] b_emag_reg;
    logic [63:0] c_prod_reg;
    logic [22:0] e_vd_reg;
    logic [31:0] g_x_reg, r_newv_reg;
    logic        g_neg_reg, r_neg_reg;
    logic [32:0] g_newv_reg;
    logic [31:0] g_acc_reg, r_acc_reg;
    logic [22:0] r_vmag_reg;
    logic [2:0]  o_joint_reg;
    logic [31:0] o_pos_reg, o_vel_reg, o_acc_reg;

    logic [31:0] sqrt_root;

    assign adv      = !o_valid_reg || m_tready;
    assign head_idx = head.item.joint[JW-1:0];
    assign pop      = adv && head.valid &&
                      ((head.item.kind == KIND_SKIP) || !busy_reg[head_idx]);

    // stage b: error and snap test
    logic signed [32:0] b_err;
    logic [31:0]        b_emag, b_velmag;
    jtl_ctx_t           b_ctx;
    always_comb begin
        b_err    = $signed({a_ctx_reg.desired[31], a_ctx_reg.desired}) -
                   $signed({a_ctx_reg.pos[31], a_ctx_reg.pos});
        b_emag   = b_err[32] ? 32'(-b_err) : b_err[31:0];
        b_velmag = a_ctx_reg.vel[31] ? (~a_ctx_reg.vel + 32'd1) : a_ctx_reg.vel;
        b_ctx        = a_ctx_reg;
        b_ctx.errneg = b_err[32];
        if ((a_ctx_reg.kind == KIND_STEP) && (b_emag <= 32'd1) &&
            (b_velmag <= {10'd0, limits.step})) begin
            b_ctx.kind = KIND_SNAP;
        end
    end

    jtl_ctx_t line_in;
    always_comb begin
        line_in     = c_ctx_reg;
        line_in.cmp = (c_prod_reg >= {4'd0, limits.vsq});
    end

    jtl_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (adv),
        .radicand (c_prod_reg),
        .root     (sqrt_root)
    );

    // stage e: target speed and clamped velocity change
    logic [31:0]        e_speed;
    logic signed [33:0] e_dv;
    logic signed [34:0] e_vd_raw, e_s_pos, e_s_neg;
    logic [22:0]        e_vd;
    jtl_ctx_t           e_in;
    always_comb begin
        e_in    = line_reg[SQRT_STEPS-1];
        e_speed = e_in.cmp ? {2'd0, limits.vlim} : sqrt_root;
        e_dv    = e_in.errneg ? -$signed({2'd0, e_speed}) : $signed({2'd0, e_speed});
        e_vd_raw = $signed({e_dv[33], e_dv}) - $signed({{3{e_in.vel[31]}}, e_in.vel});
        e_s_pos  = $signed({13'd0, limits.step});
        e_s_neg  = -e_s_pos;
        if (e_vd_raw > e_s_pos) begin
            e_vd = e_s_pos[22:0];
        end else if (e_vd_raw < e_s_neg) begin
            e_vd = e_s_neg[22:0];
        end else begin
            e_vd = e_vd_raw[22:0];
        end
    end

    // stage g: new velocity, rounding operand, acceleration times 1000
    logic signed [32:0] g_newv, g_abs;
    logic signed [47:0] g_vd48, g_vel48, g_acc_step, g_acc_snap;
    always_comb begin
        g_newv  = $signed({e_ctx_reg.vel[31], e_ctx_reg.vel}) +
                  $signed({{10{e_vd_reg[22]}}, e_vd_reg});
        g_abs   = g_newv[32] ? -g_newv : g_newv;
        g_vd48  = $signed({{25{e_vd_reg[22]}}, e_vd_reg});
        g_vel48 = $signed({{16{e_ctx_reg.vel[31]}}, e_ctx_reg.vel});
        g_acc_step = (g_vd48 <<< 10) - (g_vd48 <<< 4) - (g_vd48 <<< 3);
        g_acc_snap = -((g_vel48 <<< 10) - (g_vel48 <<< 4) - (g_vel48 <<< 3));
    end

    // stage r: divide by 1000 through the reciprocal
    logic [60:0] r_prod;
    assign r_prod = 61'(g_x_reg) * 61'(DIV1000_MUL);

    // stage o: position step with saturation and result select
    logic signed [32:0] o_step;
    logic signed [33:0] o_sum;
    logic [31:0]        o_newp;
    always_comb begin
        o_step = r_neg_reg ? -$signed({10'd0, r_vmag_reg}) : $signed({10'd0, r_vmag_reg});
        o_sum  = $signed({{2{r_ctx_reg.pos[31]}}, r_ctx_reg.pos}) +
                 $signed({o_step[32], o_step});
        o_newp = sat32(48'(o_sum));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                line_valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            a_valid_reg <= pop;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            line_valid_reg[0] <= c_valid_reg;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                line_valid_reg[k] <= line_valid_reg[k-1];
            end
            e_valid_reg <= line_valid_reg[SQRT_STEPS-1];
            g_valid_reg <= e_valid_reg;
            r_valid_reg <= g_valid_reg;
            o_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_ctx_reg.kind    <= head.item.kind;
            a_ctx_reg.joint   <= head.item.joint;
            a_ctx_reg.desired <= head.item.desired;
            a_ctx_reg.pos     <= pos_reg[head_idx];
            a_ctx_reg.vel     <= vel_reg[head_idx];
            a_ctx_reg.errneg  <= 1'b0;
            a_ctx_reg.cmp     <= 1'b0;

            b_ctx_reg  <= b_ctx;
            b_emag_reg <= b_emag;

            c_ctx_reg  <= b_ctx_reg;
            c_prod_reg <= 64'({limits.acc, 1'b0}) * 64'(b_emag_reg);

            line_reg[0] <= line_in;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                line_reg[k] <= line_reg[k-1];
            end

            e_ctx_reg <= e_in;
            e_vd_reg  <= e_vd;

            g_ctx_reg  <= e_ctx_reg;
            g_newv_reg <= g_newv;
            g_neg_reg  <= g_newv[32];
            g_x_reg    <= g_abs[31:0] + HALF_TICKS;
            g_acc_reg  <= (e_ctx_reg.kind == KIND_SNAP) ? sat32(g_acc_snap)
                                                        : sat32(g_acc_step);

            r_ctx_reg  <= g_ctx_reg;
            r_newv_reg <= g_newv_reg[31:0];
            r_neg_reg  <= g_neg_reg;
            r_acc_reg  <= g_acc_reg;
            r_vmag_reg <= r_prod[DIV1000_SHIFT +: 23];

            o_joint_reg <= r_ctx_reg.joint;
            case (r_ctx_reg.kind)
                KIND_STEP: begin
                    o_pos_reg <= o_newp;
                    o_vel_reg <= r_newv_reg;
                    o_acc_reg <= r_acc_reg;
                end
                KIND_PRESET: begin
                    o_pos_reg <= r_ctx_reg.desired;
                    o_vel_reg <= '0;
                    o_acc_reg <= '0;
                end
                KIND_SNAP: begin
                    o_pos_reg <= r_ctx_reg.desired;
                    o_vel_reg <= '0;
                    o_acc_reg <= r_acc_reg;
                end
                default: begin
                    o_pos_reg <= '0;
                    o_vel_reg <= '0;
                    o_acc_reg <= '0;
                end
            endcase
        end
    end

    // joint state and in-flight marks
    logic          wb;
    logic [JW-1:0] wb_idx;
    assign wb     = adv && r_valid_reg && (r_ctx_reg.kind != KIND_SKIP);
    assign wb_idx = r_ctx_reg.joint[JW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NJ; i++) begin
                pos_reg[i]  <= '0;
                vel_reg[i]  <= '0;
                busy_reg[i] <= 1'b0;
            end
        end else begin
            if (wb) begin
                busy_reg[wb_idx] <= 1'b0;
                if (r_ctx_reg.kind == KIND_STEP) begin
                    pos_reg[wb_idx] <= o_newp;
                    vel_reg[wb_idx] <= r_newv_reg;
                end else begin
                    pos_reg[wb_idx] <= r_ctx_reg.desired;
                    vel_reg[wb_idx] <= '0;
                end
            end
            if (pop && (head.item.kind != KIND_SKIP)) begin
                busy_reg[head_idx] <= 1'b1;
            end
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {5'd0, o_acc_reg, o_vel_reg, o_pos_reg, o_joint_reg};

`ifndef SYNTHESIS
    a_wb_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        wb |-> busy_reg[wb_idx])
        else $error("state write for a joint not marked in flight");
    a_stall_holds_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(a_valid_reg) && $stable(o_valid_reg))
        else $error("pipeline moved during output stall");
`endif

endmodule

// ----- design/joint_trajectory_limiter_unit.sv -----
// channel   dir  handshake             payload
// s_*       in   s_tvalid / s_tready   s_tdata: joint_index, desired_position; s_tuser: action
// m_*       out  m_tvalid / m_tready   m_tdata: joint_out, position, velocity, acceleration
// cfg_*     in   cfg_we (no wait)      cfg_index, cfg_wdata
//
// one item per cycle for items on different joints while m_tready does not stall the pipeline
// an item on a joint already in flight waits at the queue head until the earlier one writes
// back, so items on one joint are spaced by the back pipeline, mostly the 32-stage square root
// aresetn is synchronous: clears joint state, queue and stage valids, loads reset limits
// a stalled m_tready freezes the back pipeline; the 4-entry queue keeps accepting until full
module joint_trajectory_limiter_unit import jtl_pkg::*; #(
    parameter int NUM_JOINTS = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // joint_index[2:0], desired_position[34:3], zero pad
    input  logic         s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // joint_out[2:0], position_out[34:3],
                                    // velocity_out[66:35], acceleration_out[98:67], zero pad
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [30:0]  cfg_wdata
);

    logic [29:0] velocity_limit_reg;
    logic [30:0] acceleration_limit_reg;
    logic [21:0] step_reg;
    logic [59:0] vsq_reg;
    logic [60:0] step_prod;
    jtl_limits_t limits;
    jtl_head_t   head;
    logic        pop;

    // config registers, bits above each width dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            velocity_limit_reg     <= VEL_LIMIT_RESET;
            acceleration_limit_reg <= ACC_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_VELOCITY_LIMIT:     velocity_limit_reg     <= cfg_wdata[29:0];
                CFG_ACCELERATION_LIMIT: acceleration_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-tick velocity step (acc + 500) / 1000 and squared speed limit
    assign step_prod = 61'(32'(acceleration_limit_reg) + HALF_TICKS) * 61'(DIV1000_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_RESET;
            vsq_reg  <= VSQ_RESET;
        end else begin
            step_reg <= step_prod[DIV1000_SHIFT +: 22];
            vsq_reg  <= 60'(velocity_limit_reg) * 60'(velocity_limit_reg);
        end
    end

    assign limits.vlim = velocity_limit_reg;
    assign limits.acc  = acceleration_limit_reg;
    assign limits.step = step_reg;
    assign limits.vsq  = vsq_reg;

    // front: accept, classify, queue
    jtl_front #(
        .NUM_JOINTS (NUM_JOINTS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .head     (head),
        .pop      (pop)
    );

    // back: state read, limiter pipeline, write-back, output register
    jtl_back #(
        .NUM_JOINTS (NUM_JOINTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .limits   (limits),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
